### rtl/rac_pkg.sv
package rac_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned RING_W   = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PERM_W   = 8;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK  = 2'd0,
    OP_CREATE = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_BAD_INDEX      = 3'd1,
    ST_ALREADY_ACTIVE = 3'd2,
    ST_NOT_ACTIVE     = 3'd3,
    ST_FULL           = 3'd4
  } status_t;

  // One stored region: inclusive start, exclusive end, granted permissions.
  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] limit_addr;
    logic [PERM_W-1:0] perms;
  } region_t;

  // Access under check; last is addr + size carried in one extra bit.
  typedef struct packed {
    logic [ADDR_W:0]   last;
    logic [ADDR_W-1:0] addr;
    logic [PERM_W-1:0] kind;
  } access_t;

endpackage

### rtl/rac_in_if.sv
interface rac_in_if;
  logic                       valid;
  logic                       ready;
  logic [rac_pkg::OP_W-1:0]   opcode;
  logic [rac_pkg::RING_W-1:0] ring_index;
  logic [rac_pkg::ADDR_W-1:0] access_addr;
  logic [rac_pkg::ADDR_W-1:0] access_size;
  logic [rac_pkg::PERM_W-1:0] access_kind;
  logic [rac_pkg::ADDR_W-1:0] region_start;
  logic [rac_pkg::ADDR_W-1:0] region_end;
  logic [rac_pkg::PERM_W-1:0] region_perms;

  modport source (
    output valid, opcode, ring_index, access_addr, access_size, access_kind,
           region_start, region_end, region_perms,
    input  ready
  );

  modport sink (
    input  valid, opcode, ring_index, access_addr, access_size, access_kind,
           region_start, region_end, region_perms,
    output ready
  );
endinterface

### rtl/rac_out_if.sv
interface rac_out_if;
  logic                         valid;
  logic                         ready;
  logic [rac_pkg::STATUS_W-1:0] status;
  logic                         allowed;

  modport source (
    output valid, status, allowed,
    input  ready
  );

  modport sink (
    input  valid, status, allowed,
    output ready
  );
endinterface

### rtl/rac_ram.sv
module rac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rac_region_cmp.sv
module rac_region_cmp (
  input  rac_pkg::region_t region,
  input  rac_pkg::access_t access,
  output logic             hit
);

  logic start_ok;
  logic end_ok;
  logic perm_ok;

  assign start_ok = access.addr >= region.start_addr;
  assign end_ok   = access.last <= {1'b0, region.limit_addr};
  assign perm_ok  = (region.perms & access.kind) == access.kind;
  assign hit      = start_ok && end_ok && perm_ok;

endmodule

### rtl/region_access_checker_unit.sv
// Region access checker: a protection table of NUM_RINGS rings, each holding
// up to REGIONS_PER_RING address regions with permission masks. Each input
// transaction carries one operation (check, create, add region, remove) and
// yields exactly one result transaction with a status and, for a check, the
// grant. Ring state (active flag, region count) lives in a small RAM with one
// valid flop per ring, so reset takes effect at once and no clearing pass is
// needed; region entries live in a second RAM of NUM_RINGS*REGIONS_PER_RING
// rows. One operation is in flight at a time. A check of ring 0 or any
// operation on a bad ring index goes from accept straight to the result;
// other operations pass through accept, ring-state read and result. A
// check of an active ring with n regions reads the region RAM one row per
// cycle and stops at the first hit or after the last of the n rows; the
// region RAM has a single read port. A new transaction is taken while the
// previous result still waits at the output register.
module region_access_checker_unit #(
  parameter int unsigned NUM_RINGS        = 8,
  parameter int unsigned REGIONS_PER_RING = 8
) (
  input logic     clk,
  input logic     rst_n,
  rac_in_if.sink  in_chan,
  rac_out_if.source out_chan
);

  localparam int unsigned RIDX_W    = $clog2(NUM_RINGS);
  localparam int unsigned CNT_W     = $clog2(REGIONS_PER_RING + 1);
  localparam int unsigned TAB_DEPTH = NUM_RINGS * REGIONS_PER_RING;
  localparam int unsigned TAB_W     = $clog2(TAB_DEPTH);
  localparam int unsigned RENT_W    = CNT_W + 1;
  localparam int unsigned REG_BITS  = $bits(rac_pkg::region_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RING,
    S_SCAN,
    S_RESP
  } state_t;

  state_t               state_r;
  rac_pkg::op_t         op_r;
  logic [RIDX_W-1:0]    ring_r;
  rac_pkg::access_t     access_r;
  rac_pkg::region_t     region_in_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     k_r;
  rac_pkg::status_t     res_status_r;
  logic                 res_allowed_r;
  rac_pkg::status_t     out_status_r;
  logic                 out_allowed_r;
  logic                 out_valid_r;
  logic [NUM_RINGS-1:0] ring_vld_r;

  logic                 accept;
  logic                 ring_zero_check;
  logic                 bad_index;

  // ring-state RAM
  logic [RIDX_W-1:0]    ring_rd_addr;
  logic [RENT_W-1:0]    ring_rd_data;
  logic                 ring_we;
  logic [RENT_W-1:0]    ring_wdata;
  logic                 active_rd;
  logic [CNT_W-1:0]     count_rd;
  logic                 full;

  // region RAM
  logic [TAB_W-1:0]     tab_base;
  logic [TAB_W-1:0]     tab_wr_addr;
  logic [TAB_W-1:0]     tab_rd_addr;
  logic [CNT_W-1:0]     tab_rd_idx;
  logic                 tab_we;
  logic [REG_BITS-1:0]  tab_rd_data;
  rac_pkg::region_t     region_rd;
  logic                 hit;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // Ring 0 checks are granted unconditionally; ring index range test.
  assign ring_zero_check = (rac_pkg::op_t'(in_chan.opcode) == rac_pkg::OP_CHECK)
                           && (in_chan.ring_index == '0);
  assign bad_index       = {24'd0, in_chan.ring_index} >= NUM_RINGS;

  // A ring whose valid flop is clear reads as inactive with no regions.
  assign active_rd = ring_vld_r[ring_r] & ring_rd_data[CNT_W];
  assign count_rd  = ring_vld_r[ring_r] ? ring_rd_data[CNT_W-1:0] : '0;
  assign full      = count_rd >= CNT_W'(REGIONS_PER_RING);

  always_comb begin
    ring_rd_addr = (state_r == S_IDLE) ? in_chan.ring_index[RIDX_W-1:0] : ring_r;
    ring_we      = 1'b0;
    ring_wdata   = '0;
    tab_we       = 1'b0;
    if (state_r == S_RING) begin
      case (op_r)
        rac_pkg::OP_CREATE: begin
          ring_we    = !active_rd;
          ring_wdata = {1'b1, {CNT_W{1'b0}}};
        end
        rac_pkg::OP_ADD: begin
          ring_we    = active_rd && !full;
          tab_we     = active_rd && !full;
          ring_wdata = {1'b1, count_rd + CNT_W'(1)};
        end
        rac_pkg::OP_REMOVE: begin
          ring_we    = active_rd;
          ring_wdata = '0;
        end
        default: begin
          ring_we    = 1'b0;
        end
      endcase
    end
  end

  // Row address: ring base plus region slot. Prefetch slot 0 while the ring
  // state is decoded, then slot k+1 while slot k is compared.
  assign tab_base    = TAB_W'(ring_r) * TAB_W'(REGIONS_PER_RING);
  assign tab_wr_addr = tab_base + TAB_W'(count_rd);
  assign tab_rd_idx  = (state_r == S_SCAN) ? (k_r + CNT_W'(1)) : '0;
  assign tab_rd_addr = tab_base + TAB_W'(tab_rd_idx);
  assign region_rd   = rac_pkg::region_t'(tab_rd_data);

  rac_ram #(
    .WIDTH (RENT_W),
    .DEPTH (NUM_RINGS)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_r),
    .wr_data (ring_wdata),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  rac_ram #(
    .WIDTH (REG_BITS),
    .DEPTH (TAB_DEPTH)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_wr_addr),
    .wr_data (region_in_r),
    .rd_addr (tab_rd_addr),
    .rd_data (tab_rd_data)
  );

  rac_region_cmp u_cmp (
    .region (region_rd),
    .access (access_r),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ring_vld_r  <= '0;
    end else begin
      // drop the result once the sink takes it, unless a new one replaces it
      if (out_valid_r && out_chan.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      if (ring_we) begin
        ring_vld_r[ring_r] <= 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r                   <= rac_pkg::op_t'(in_chan.opcode);
            ring_r                 <= in_chan.ring_index[RIDX_W-1:0];
            access_r.addr          <= in_chan.access_addr;
            access_r.last          <= {1'b0, in_chan.access_addr}
                                      + {1'b0, in_chan.access_size};
            access_r.kind          <= in_chan.access_kind;
            region_in_r.start_addr <= in_chan.region_start;
            region_in_r.limit_addr <= in_chan.region_end;
            region_in_r.perms      <= in_chan.region_perms;
            if (ring_zero_check) begin
              res_status_r  <= rac_pkg::ST_OK;
              res_allowed_r <= 1'b1;
              state_r       <= S_RESP;
            end else if (bad_index) begin
              res_status_r  <= rac_pkg::ST_BAD_INDEX;
              res_allowed_r <= 1'b0;
              state_r       <= S_RESP;
            end else begin
              res_allowed_r <= 1'b0;
              state_r       <= S_RING;
            end
          end
        end

        S_RING: begin
          case (op_r)
            rac_pkg::OP_CHECK: begin
              if (!active_rd) begin
                res_status_r <= rac_pkg::ST_NOT_ACTIVE;
                state_r      <= S_RESP;
              end else if (count_rd != '0) begin
                // region slot 0 is already being read
                res_status_r <= rac_pkg::ST_OK;
                count_r      <= count_rd;
                k_r          <= '0;
                state_r      <= S_SCAN;
              end else begin
                res_status_r <= rac_pkg::ST_OK;
                state_r      <= S_RESP;
              end
            end
            rac_pkg::OP_CREATE: begin
              state_r <= S_RESP;
              if (active_rd) begin
                res_status_r <= rac_pkg::ST_ALREADY_ACTIVE;
              end else begin
                res_status_r <= rac_pkg::ST_OK;
              end
            end
            rac_pkg::OP_ADD: begin
              state_r <= S_RESP;
              if (!active_rd) begin
                res_status_r <= rac_pkg::ST_NOT_ACTIVE;
              end else if (full) begin
                res_status_r <= rac_pkg::ST_FULL;
              end else begin
                res_status_r <= rac_pkg::ST_OK;
              end
            end
            rac_pkg::OP_REMOVE: begin
              state_r <= S_RESP;
              if (!active_rd) begin
                res_status_r <= rac_pkg::ST_NOT_ACTIVE;
              end else begin
                res_status_r <= rac_pkg::ST_OK;
              end
            end
            default: begin
              state_r      <= S_RESP;
              res_status_r <= rac_pkg::ST_OK;
            end
          endcase
        end

        S_SCAN: begin
          // stop at the first region that contains the access
          if (hit) begin
            res_allowed_r <= 1'b1;
            state_r       <= S_RESP;
          end else if ((k_r + CNT_W'(1)) == count_r) begin
            state_r <= S_RESP;
          end else begin
            k_r <= k_r + CNT_W'(1);
          end
        end

        S_RESP: begin
          // hold until the output register is free
          if (!out_valid_r || out_chan.ready) begin
            out_status_r  <= res_status_r;
            out_allowed_r <= res_allowed_r;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.allowed = out_allowed_r;

endmodule
